>>> rtl/qed_pkg.sv
`timescale 1ns / 1ps

package qed_pkg;

  localparam int unsigned STEPS_PER_DETENT_DEF = 4;
  localparam int unsigned INVALID_WIDTH_DEF    = 16;

  localparam int unsigned PhaseW     = 2;
  localparam int unsigned PhaseCntW  = 8;
  localparam int unsigned ButtonCntW = 16;
  localparam int unsigned TotalW     = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CFG_PHASE_STABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INIT_PHASE   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INIT_PRESSED = 2'd3;

  localparam logic [PhaseCntW-1:0]  PHASE_STABLE_RST = 8'd4;
  localparam logic [ButtonCntW-1:0] BUTTON_TICKS_RST = 16'd1000;
  localparam logic [PhaseW-1:0]     INIT_PHASE_RST   = 2'd0;
  localparam logic                  INIT_PRESSED_RST = 1'b0;

  typedef struct packed {
    logic cw;
    logic ccw;
  } phase_evt_t;

  typedef struct packed {
    logic press;
    logic release_evt;
  } button_evt_t;

  typedef struct packed {
    logic              step_cw;
    logic              step_ccw;
    logic              press_event;
    logic              release_event;
    logic [TotalW-1:0] invalid_total;
  } result_t;

  // Gray-code step: index is {old phase, new phase}
  function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx) inside
      4'd1, 4'd7, 4'd8, 4'd14:  d = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
      default:                  d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/qed_in_if.sv
`timescale 1ns / 1ps

interface qed_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase_in;
  logic       button_in;

  modport source (output valid, output phase_in, output button_in, input ready);
  modport sink   (input valid, input phase_in, input button_in, output ready);
endinterface

>>> rtl/qed_out_if.sv
`timescale 1ns / 1ps

interface qed_out_if;
  logic        valid;
  logic        ready;
  logic        step_cw;
  logic        step_ccw;
  logic        press_event;
  logic        release_event;
  logic [15:0] invalid_total;

  modport source (output valid, output step_cw, output step_ccw, output press_event,
                  output release_event, output invalid_total, input ready);
  modport sink   (input valid, input step_cw, input step_ccw, input press_event,
                  input release_event, input invalid_total, output ready);
endinterface

>>> rtl/quadrature_encoder_debounce_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    phase_in[1:0], button_in
// out_o     out  valid/ready    step_cw, step_ccw, press_event, release_event,
//                               invalid_total[15:0]
// cfg       in   cfg_we_i       cfg_index_i[1:0], cfg_wdata_i[15:0]
//
// One transaction in gives one transaction out, registered in the cycle after it is accepted.
// Throughput is one transaction per cycle while out_o.ready is high; the result register is the only stage.
// in_i.ready is high while the result register is empty or being drained.
// Reset loads the register defaults and the matching start state.

module quadrature_encoder_debounce_core #(
  parameter int unsigned STEPS_PER_DETENT = qed_pkg::STEPS_PER_DETENT_DEF,
  parameter int unsigned INVALID_WIDTH    = qed_pkg::INVALID_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qed_in_if.sink                        in_i,
  qed_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [qed_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [qed_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  logic [qed_pkg::PhaseCntW-1:0]  stable_samples_q;
  logic [qed_pkg::ButtonCntW-1:0] ticks_q;
  logic [qed_pkg::PhaseW-1:0]     init_phase_q;
  logic                           init_pressed_q;
  logic                           load_phase, load_button;

  logic                 in_fire;
  logic                 out_valid_q;
  qed_pkg::result_t     out_q, out_d;
  qed_pkg::phase_evt_t  phase_evt;
  qed_pkg::button_evt_t button_evt;
  logic [INVALID_WIDTH-1:0] inv_cnt;
  logic [31:0]          inv_ext;

  always_comb begin
    load_phase  = 1'b0;
    load_button = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        qed_pkg::CFG_INIT_PHASE:   load_phase  = 1'b1;
        qed_pkg::CFG_INIT_PRESSED: load_button = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_samples_q <= qed_pkg::PHASE_STABLE_RST;
      ticks_q          <= qed_pkg::BUTTON_TICKS_RST;
      init_phase_q     <= qed_pkg::INIT_PHASE_RST;
      init_pressed_q   <= qed_pkg::INIT_PRESSED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qed_pkg::CFG_PHASE_STABLE: stable_samples_q <= cfg_wdata_i[qed_pkg::PhaseCntW-1:0];
        qed_pkg::CFG_BUTTON_TICKS: ticks_q          <= cfg_wdata_i[qed_pkg::ButtonCntW-1:0];
        qed_pkg::CFG_INIT_PHASE:   init_phase_q     <= cfg_wdata_i[qed_pkg::PhaseW-1:0];
        qed_pkg::CFG_INIT_PRESSED: init_pressed_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  qed_phase #(
    .STEPS_PER_DETENT (STEPS_PER_DETENT),
    .INVALID_WIDTH    (INVALID_WIDTH)
  ) u_phase (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (in_fire),
    .load_i           (load_phase),
    .init_phase_i     (cfg_wdata_i[qed_pkg::PhaseW-1:0]),
    .stable_samples_i (stable_samples_q),
    .phase_i          (in_i.phase_in),
    .evt_o            (phase_evt),
    .inv_cnt_o        (inv_cnt)
  );

  qed_button u_button (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (in_fire),
    .load_i         (load_button),
    .init_pressed_i (cfg_wdata_i[0]),
    .ticks_i        (ticks_q),
    .button_i       (in_i.button_in),
    .evt_o          (button_evt)
  );

  assign inv_ext = 32'(inv_cnt);

  always_comb begin
    out_d.step_cw       = phase_evt.cw;
    out_d.step_ccw      = phase_evt.ccw;
    out_d.press_event   = button_evt.press;
    out_d.release_event = button_evt.release_evt;
    out_d.invalid_total = inv_ext[qed_pkg::TotalW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.step_cw       = out_q.step_cw;
  assign out_o.step_ccw      = out_q.step_ccw;
  assign out_o.press_event   = out_q.press_event;
  assign out_o.release_event = out_q.release_event;
  assign out_o.invalid_total = out_q.invalid_total;

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction did not reach the result register");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid_q)
    else $error("input stalled with an empty result register");

  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.step_cw && out_q.step_ccw))
    else $error("both detent directions in one result");

  a_btn_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.press_event && out_q.release_event))
    else $error("press and release in one result");

endmodule

>>> rtl/qed_phase.sv
`timescale 1ns / 1ps

module qed_phase #(
  parameter int unsigned STEPS_PER_DETENT = qed_pkg::STEPS_PER_DETENT_DEF,
  parameter int unsigned INVALID_WIDTH    = qed_pkg::INVALID_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             load_i,
  input  logic [qed_pkg::PhaseW-1:0]       init_phase_i,
  input  logic [qed_pkg::PhaseCntW-1:0]    stable_samples_i,
  input  logic [qed_pkg::PhaseW-1:0]       phase_i,
  output qed_pkg::phase_evt_t              evt_o,
  output logic [INVALID_WIDTH-1:0]         inv_cnt_o
);

  localparam int unsigned SumW = $clog2(STEPS_PER_DETENT + 1) + 1;
  localparam logic signed [SumW-1:0] DetentPos = SumW'(STEPS_PER_DETENT);
  localparam logic signed [SumW-1:0] DetentNeg = -DetentPos;

  logic [qed_pkg::PhaseW-1:0]    stable_q, stable_d;
  logic [qed_pkg::PhaseW-1:0]    cand_q, cand_d;
  logic [qed_pkg::PhaseCntW-1:0] hold_q, hold_d, hold_inc;
  logic signed [SumW-1:0]        sum_q, sum_d, sum_add;
  logic [INVALID_WIDTH-1:0]      inv_q, inv_d;
  logic signed [1:0]             delta;
  logic                          accept_step;
  logic                          jump;

  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    hold_d   = hold_q;
    sum_d    = sum_q;
    inv_d    = inv_q;
    evt_o    = '0;
    hold_inc = ((phase_i != cand_q) ? '0 : hold_q) + 1'b1;
    jump     = ((phase_i ^ stable_q) == 2'b11);
    delta    = qed_pkg::gray_delta({stable_q, phase_i});
    sum_add  = sum_q + SumW'(delta);
    accept_step = 1'b0;
    if (phase_i == stable_q) begin
      cand_d = phase_i;
      hold_d = '0;
    end else begin
      cand_d = phase_i;
      hold_d = hold_inc;
      if (hold_inc >= stable_samples_i) begin
        accept_step = 1'b1;
        stable_d    = phase_i;
        hold_d      = '0;
        if (jump) begin
          sum_d = '0;
          inv_d = inv_q + 1'b1;
        end else if (sum_add >= DetentPos) begin
          evt_o.cw = 1'b1;
          sum_d    = '0;
        end else if (sum_add <= DetentNeg) begin
          evt_o.ccw = 1'b1;
          sum_d     = '0;
        end else begin
          sum_d = sum_add;
        end
      end
    end
  end

  assign inv_cnt_o = inv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= qed_pkg::INIT_PHASE_RST;
      cand_q   <= qed_pkg::INIT_PHASE_RST;
      hold_q   <= '0;
      sum_q    <= '0;
      inv_q    <= '0;
    end else if (load_i) begin
      stable_q <= init_phase_i;
      cand_q   <= init_phase_i;
      hold_q   <= '0;
      sum_q    <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      hold_q   <= hold_d;
      sum_q    <= sum_d;
      inv_q    <= inv_d;
    end
  end

  a_inv_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inv_q == $past(inv_q)) || (inv_q == $past(inv_q) + 1'b1))
    else $error("invalid count moved by more than one");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q < DetentPos) && (sum_q > DetentNeg))
    else $error("movement sum holds a full detent");

  a_evt_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.cw || evt_o.ccw) |-> (accept_step && !jump))
    else $error("detent without an accepted step");

endmodule

>>> rtl/qed_button.sv
`timescale 1ns / 1ps

module qed_button (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           load_i,
  input  logic                           init_pressed_i,
  input  logic [qed_pkg::ButtonCntW-1:0] ticks_i,
  input  logic                           button_i,
  output qed_pkg::button_evt_t           evt_o
);

  logic                           level_q, level_d;
  logic                           armed_q, armed_d;
  logic [qed_pkg::ButtonCntW-1:0] hold_q, hold_d, hold_inc;

  always_comb begin
    level_d  = level_q;
    armed_d  = armed_q;
    evt_o    = '0;
    hold_inc = hold_q + 1'b1;
    if (button_i == level_q) begin
      hold_d = '0;
    end else if (hold_inc >= ticks_i) begin
      hold_d            = '0;
      level_d           = button_i;
      evt_o.press       = armed_q & button_i;
      evt_o.release_evt = armed_q & ~button_i;
      if (!button_i) begin
        armed_d = 1'b1;
      end
    end else begin
      hold_d = hold_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= qed_pkg::INIT_PRESSED_RST;
      armed_q <= ~qed_pkg::INIT_PRESSED_RST;
      hold_q  <= '0;
    end else if (load_i) begin
      level_q <= init_pressed_i;
      armed_q <= ~init_pressed_i;
      hold_q  <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      armed_q <= armed_d;
      hold_q  <= hold_d;
    end
  end

  a_disarmed_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> level_q)
    else $error("disarmed while released");

endmodule

>>> tb/qed_event_checker.sv
`timescale 1ns / 1ps

module qed_event_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qed_in_if                            in_i,
  qed_out_if                           out_i,
  input  logic                         cfg_we_i,
  input  logic [qed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qed_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o
);

  import qed_pkg::*;

  localparam int DetentSteps = int'(STEPS_PER_DETENT_DEF);
  localparam int GrayStep [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

  logic [PhaseCntW-1:0]  need_ph_samples;
  logic [ButtonCntW-1:0] need_btn_ticks;
  logic [PhaseW-1:0]     start_phase;
  logic                  start_pressed;

  logic [PhaseW-1:0]     stable_ph;
  logic [PhaseW-1:0]     cand_ph;
  logic [PhaseCntW-1:0]  ph_hold;
  int                    move_sum;
  logic [TotalW-1:0]     jump_count;
  logic                  btn_level;
  logic                  btn_armed;
  logic [ButtonCntW-1:0] btn_hold;

  result_t     expected_events [$];
  int unsigned mismatches;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  function automatic void load_phase_state();
    stable_ph = start_phase;
    cand_ph   = start_phase;
    ph_hold   = '0;
    move_sum  = 0;
  endfunction

  function automatic void load_button_state();
    btn_level = start_pressed;
    btn_armed = ~start_pressed;
    btn_hold  = '0;
  endfunction

  function automatic void apply_write(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_PHASE_STABLE: need_ph_samples = data[PhaseCntW-1:0];
      CFG_BUTTON_TICKS: need_btn_ticks = data[ButtonCntW-1:0];
      CFG_INIT_PHASE: begin
        start_phase = data[PhaseW-1:0];
        load_phase_state();
      end
      CFG_INIT_PRESSED: begin
        start_pressed = data[0];
        load_button_state();
      end
      default: ;
    endcase
  endfunction

  function automatic result_t decode_sample(input logic [PhaseW-1:0] ph, input logic btn);
    result_t r;
    r = '0;
    if (ph == stable_ph) begin
      cand_ph = ph;
      ph_hold = '0;
    end else begin
      if (ph != cand_ph) begin
        cand_ph = ph;
        ph_hold = '0;
      end
      ph_hold = ph_hold + 1'b1;
      if (ph_hold >= need_ph_samples) begin
        if ((ph ^ stable_ph) == 2'b11) begin
          move_sum   = 0;
          jump_count = jump_count + 1'b1;
        end else begin
          move_sum += GrayStep[{stable_ph, ph}];
        end
        stable_ph = ph;
        ph_hold   = '0;
        if (move_sum >= DetentSteps) begin
          r.step_cw = 1'b1;
          move_sum  = 0;
        end else if (move_sum <= -DetentSteps) begin
          r.step_ccw = 1'b1;
          move_sum   = 0;
        end
      end
    end

    if (btn == btn_level) begin
      btn_hold = '0;
    end else begin
      btn_hold = btn_hold + 1'b1;
      if (btn_hold >= need_btn_ticks) begin
        btn_hold  = '0;
        btn_level = btn;
        if (btn_armed) begin
          r.press_event   = btn;
          r.release_event = ~btn;
        end
        if (!btn) btn_armed = 1'b1;
      end
    end
    r.invalid_total = jump_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      need_ph_samples = PHASE_STABLE_RST;
      need_btn_ticks  = BUTTON_TICKS_RST;
      start_phase     = INIT_PHASE_RST;
      start_pressed   = INIT_PRESSED_RST;
      load_phase_state();
      load_button_state();
      jump_count = '0;
      expected_events.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.step_cw, out_i.step_ccw, out_i.press_event, out_i.release_event,
                out_i.invalid_total};
        if (expected_events.size() == 0) begin
          report_mismatch("result transaction with no sample outstanding");
        end else begin
          want = expected_events.pop_front();
          if (got.step_cw !== want.step_cw)
            report_mismatch($sformatf("step_cw got %b want %b", got.step_cw, want.step_cw));
          if (got.step_ccw !== want.step_ccw)
            report_mismatch($sformatf("step_ccw got %b want %b", got.step_ccw, want.step_ccw));
          if (got.press_event !== want.press_event)
            report_mismatch($sformatf("press_event got %b want %b",
                                      got.press_event, want.press_event));
          if (got.release_event !== want.release_event)
            report_mismatch($sformatf("release_event got %b want %b",
                                      got.release_event, want.release_event));
          if (got.invalid_total !== want.invalid_total)
            report_mismatch($sformatf("invalid_total got %0d want %0d",
                                      got.invalid_total, want.invalid_total));
        end
      end
      if (in_i.valid && in_i.ready)
        expected_events.push_back(decode_sample(in_i.phase_in, in_i.button_in));
      if (cfg_we_i) apply_write(cfg_index_i, cfg_wdata_i);
      pending_o <= expected_events.size();
    end
  end

endmodule

>>> tb/tb_quadrature_encoder_debounce_core.sv
`timescale 1ns / 1ps

module tb_quadrature_encoder_debounce_core;

  import qed_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned JumpItems  = 50;
  localparam int unsigned NumDirected = 16;
  // {phase, button}
  localparam logic [2:0] Directed [NumDirected] = '{
    3'b101, 3'b001, 3'b011, 3'b111, 3'b010, 3'b000, 3'b101, 3'b111,
    3'b000, 3'b110, 3'b011, 3'b101, 3'b100, 3'b000, 3'b001, 3'b000
  };

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int unsigned mismatches;
  int unsigned pending;

  qed_in_if  in_ch ();
  qed_out_if out_ch ();

  quadrature_encoder_debounce_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  qed_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned quiet_cycles;

  // stimulus shaping state
  logic [PhaseCntW-1:0]  cur_pss;
  logic [ButtonCntW-1:0] cur_ticks;
  logic [PhaseW-1:0]     gen_phase;
  logic                  gen_cw;
  logic                  gen_btn;
  int unsigned           ph_left;
  int unsigned           btn_left;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_quadrature_encoder_debounce_core NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [PhaseW-1:0] gray_next(input logic [PhaseW-1:0] p, input logic cw);
    logic [PhaseW-1:0] n;
    case (p)
      2'd0:    n = cw ? 2'd1 : 2'd2;
      2'd1:    n = cw ? 2'd3 : 2'd0;
      2'd3:    n = cw ? 2'd2 : 2'd1;
      default: n = cw ? 2'd0 : 2'd3;
    endcase
    return n;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_regs(input logic [CfgDataW-1:0] pss, input logic [CfgDataW-1:0] ticks,
                          input logic [CfgDataW-1:0] ph0, input logic [CfgDataW-1:0] pr0);
    write_reg(CFG_PHASE_STABLE, pss);
    write_reg(CFG_BUTTON_TICKS, ticks);
    write_reg(CFG_INIT_PHASE, ph0);
    write_reg(CFG_INIT_PRESSED, pr0);
    cur_pss   = pss[PhaseCntW-1:0];
    cur_ticks = ticks;
    gen_phase = ph0[PhaseW-1:0];
    gen_btn   = pr0[0];
    ph_left   = 0;
    btn_left  = 0;
  endtask

  task automatic push_sample(input logic [PhaseW-1:0] ph, input logic btn);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.phase_in  <= ph;
    in_ch.button_in <= btn;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // mostly held runs long enough to pass the filters, some short glitches and jumps
  task automatic next_sample(output logic [PhaseW-1:0] ph, output logic btn);
    int unsigned span;
    if (ph_left == 0) begin
      if ($urandom_range(0, 99) < 12) begin
        gen_phase = gen_phase ^ 2'b11;
      end else begin
        if ($urandom_range(0, 99) < 15) gen_cw = ~gen_cw;
        gen_phase = gray_next(gen_phase, gen_cw);
      end
      span = (cur_pss == 0) ? 1 : cur_pss;
      ph_left = ($urandom_range(0, 99) < 80) ? span + $urandom_range(0, 2)
                                             : $urandom_range(1, span);
    end
    ph_left--;
    if (btn_left == 0) begin
      gen_btn = ~gen_btn;
      span = (cur_ticks == 0) ? 1 : cur_ticks;
      btn_left = ($urandom_range(0, 99) < 80) ? span + $urandom_range(0, 3)
                                              : $urandom_range(1, span);
    end
    btn_left--;
    ph  = gen_phase;
    btn = gen_btn;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pause_at,
                            input bit jumps_only);
    logic [PhaseW-1:0] ph;
    logic              btn;
    for (int unsigned i = 0; i < count; i++) begin
      next_sample(ph, btn);
      if (jumps_only) ph = i[0] ? 2'd2 : 2'd1;
      push_sample(ph, btn);
      if (i == pause_at) drain();
    end
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.phase_in  = '0;
    in_ch.button_in = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    send_idle    = 25;
    recv_idle    = 70;
    cur_pss      = PHASE_STABLE_RST;
    cur_ticks    = BUTTON_TICKS_RST;
    gen_phase    = INIT_PHASE_RST;
    gen_btn      = INIT_PRESSED_RST;
    gen_cw       = 1'b1;
    ph_left      = 0;
    btn_left     = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_random(120, '1, 1'b0);

    // zero thresholds act as one; start pressed so the first release is silent
    set_regs(16'd0, 16'd0, 16'd3, 16'd1);
    for (int unsigned i = 0; i < NumDirected; i++)
      push_sample(Directed[i][2:1], Directed[i][0]);
    drain();

    set_regs(16'd1, 16'd1, 16'd0, 16'd0);
    run_random(200, 100, 1'b0);

    send_idle = 70;
    recv_idle = 25;
    set_regs(16'd2, 16'd3, 16'd1, 16'd0);
    run_random(180, '1, 1'b0);
    set_regs(16'd255, 16'd2, 16'd2, 16'd1);
    run_random(260, '1, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    set_regs(16'd3, 16'd65535, 16'd3, 16'd0);
    run_random(80, '1, 1'b0);
    // upper data bits are dropped; back-to-back jumps bump the invalid count
    set_regs(16'hFF01, 16'd5, 16'hFFFE, 16'hFFFF);
    run_random(JumpItems, '1, 1'b1);

    if (mismatches == 0) begin
      $display("tb_quadrature_encoder_debounce_core OK");
    end else begin
      $display("tb_quadrature_encoder_debounce_core NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qed_pkg.sv
rtl/qed_in_if.sv
rtl/qed_out_if.sv
rtl/qed_phase.sv
rtl/qed_button.sv
rtl/quadrature_encoder_debounce_core.sv
tb/qed_event_checker.sv
tb/tb_quadrature_encoder_debounce_core.sv
